// ===== design/pva_pkg.sv =====
// shared types and codes for the polyphonic voice allocator
`default_nettype none

package pva_pkg;

    localparam int CHAN_W      = 8;
    localparam int NOTE_W      = 7;
    localparam int STAMP_W     = 32;
    localparam int MASTER_W    = 5;
    localparam int ACTIVE_W    = 4;
    localparam int VOICE_W     = 3;
    localparam int STATUS_W    = 3;
    localparam int COUNT_W     = 4;
    localparam int NUM_CHANNELS = 16;
    localparam logic [COUNT_W-1:0] MAX_RESULTS = 4'd8;

    // event codes
    localparam logic [1:0] OP_NOTE_ON  = 2'd0;
    localparam logic [1:0] OP_NOTE_OFF = 2'd1;
    localparam logic [1:0] OP_ALL_OFF  = 2'd2;
    localparam logic [1:0] OP_LIST     = 2'd3;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_IDLE     = 3'd0;
    localparam logic [STATUS_W-1:0] ST_STOLEN   = 3'd1;
    localparam logic [STATUS_W-1:0] ST_RELEASED = 3'd2;
    localparam logic [STATUS_W-1:0] ST_MATCHED  = 3'd3;
    localparam logic [STATUS_W-1:0] ST_NONE     = 3'd4;

    // configuration register indexes
    localparam logic REG_MASTER = 1'b0;
    localparam logic REG_ACTIVE = 1'b1;

    typedef struct packed {
        logic                held;
        logic [CHAN_W-1:0]   chan;
        logic [NOTE_W-1:0]   note;
        logic [STAMP_W-1:0]  stamp;
    } t_voice;

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_SCAN  = 4'b0010,
        S_WRITE = 4'b0100,
        S_DONE  = 4'b1000
    } t_state;

endpackage

`default_nettype wire

// ===== design/pva_cell.sv =====
// one voice slot of the rotating voice ring
`default_nettype none

module pva_cell (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_shift,
    input  wire pva_pkg::t_voice i_d,
    output pva_pkg::t_voice      o_q
);

    pva_pkg::t_voice r_slot;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot <= '0;
        end else if (i_shift) begin
            r_slot <= i_d;
        end
    end

    assign o_q = r_slot;

endmodule

`default_nettype wire

// ===== design/pva_ring.sv =====
// ring of voice cells, each handing its slot to the cell below on a shift
`default_nettype none

module pva_ring #(
    parameter int VOICES = 8
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_shift,
    input  wire pva_pkg::t_voice i_ret,
    output pva_pkg::t_voice      o_head
);

    pva_pkg::t_voice w_q [VOICES];

    for (genvar k = 0; k < VOICES; k++) begin : g_cell
        pva_pkg::t_voice w_d;
        if (k == VOICES - 1) begin : g_tail
            assign w_d = i_ret;
        end else begin : g_mid
            assign w_d = w_q[k+1];
        end
        pva_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_shift (i_shift),
            .i_d     (w_d),
            .o_q     (w_q[k])
        );
    end

    assign o_head = w_q[0];

endmodule

`default_nettype wire

// ===== design/poly_voice_allocator.sv =====
// polyphonic voice allocator: event control around a rotating ring of voice cells
//
// Events enter on the input channel (op, channel, note) with valid/ready; one
// event is taken at a time, o_in_ready is high only while the block is idle.
// Results leave on the output channel (voice, status, last), one per transfer,
// the final result of an event marked by last. Every event gives at least one
// result. The configuration channel is always ready; write it only while idle.
// The voice slots sit in a ring of VOICES cells that rotates by one cell per
// cycle, while an event is scanned, past a head where the control logic reads
// and rewrites the slot. Note-off, all-notes-off and list events take one pass
// of the ring; note-on takes a search pass and a write pass; an ignored note-on
// skips the ring and goes straight to its final result. The ring only advances
// while the output register can take a result, so a stalled receiver freezes
// the scan without losing anything.
// Reset clears all voice slots, the stamp counter and the registers
// (master channel 0, active voices 8); the block is ready right after reset.
`default_nettype none

module poly_voice_allocator #(
    parameter int VOICES = 8
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_in_valid,
    output logic                                    o_in_ready,
    input  wire logic [1:0]                         i_op,
    input  wire logic [pva_pkg::CHAN_W-1:0]         i_channel,
    input  wire logic [pva_pkg::NOTE_W-1:0]         i_note,
    output logic                                    o_out_valid,
    input  wire logic                               i_out_ready,
    output logic [pva_pkg::VOICE_W-1:0]             o_voice,
    output logic [pva_pkg::STATUS_W-1:0]            o_status,
    output logic                                    o_last,
    input  wire logic                               i_cfg_valid,
    output logic                                    o_cfg_ready,
    input  wire logic                               i_cfg_index,
    input  wire logic [pva_pkg::MASTER_W-1:0]       i_cfg_data
);

    localparam int IW = (VOICES > 1) ? $clog2(VOICES) : 1;
    localparam int NW = (IW > pva_pkg::ACTIVE_W) ? IW : pva_pkg::ACTIVE_W;
    localparam logic [IW-1:0] LAST_IDX = IW'(VOICES - 1);
    localparam logic [pva_pkg::ACTIVE_W-1:0] VCAP = (VOICES > 15) ? 4'd15 : 4'(VOICES);

    pva_pkg::t_state                   r_state, n_state;
    logic [pva_pkg::MASTER_W-1:0]      r_master;
    logic [pva_pkg::ACTIVE_W-1:0]      r_active;
    logic [1:0]                        r_op;
    logic [pva_pkg::CHAN_W-1:0]        r_ch;
    logic [pva_pkg::NOTE_W-1:0]        r_note;
    logic [IW-1:0]                     r_idx, n_idx;
    logic [pva_pkg::COUNT_W-1:0]       r_count, n_count;
    logic                              r_done, n_done;
    logic                              r_fidle, n_fidle;
    logic [IW-1:0]                     r_pidle, n_pidle;
    logic [pva_pkg::STAMP_W-1:0]       r_bidle, n_bidle;
    logic [IW-1:0]                     r_pany, n_pany;
    logic [pva_pkg::STAMP_W-1:0]       r_bany, n_bany;
    logic [IW-1:0]                     r_pick, n_pick;
    logic [pva_pkg::STATUS_W-1:0]      r_pst, n_pst;
    logic [pva_pkg::STAMP_W-1:0]       r_stamp, n_stamp;
    logic                              r_pend_valid, n_pend_valid;
    logic [pva_pkg::VOICE_W-1:0]       r_pend_voice, n_pend_voice;
    logic [pva_pkg::STATUS_W-1:0]      r_pend_st, n_pend_st;
    logic                              r_out_valid, n_out_valid;
    logic [pva_pkg::VOICE_W-1:0]       r_out_voice, n_out_voice;
    logic [pva_pkg::STATUS_W-1:0]      r_out_st, n_out_st;
    logic                              r_out_last, n_out_last;

    pva_pkg::t_voice                   w_head, w_ret;
    logic                              w_shift, w_can_step, w_in_use, w_gen, w_ignore;
    logic [pva_pkg::ACTIVE_W-1:0]      w_n;
    logic [pva_pkg::STATUS_W-1:0]      w_gen_st;
    logic                              w_in_xfer;

    pva_ring #(.VOICES(VOICES)) u_ring (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_shift (w_shift),
        .i_ret   (w_ret),
        .o_head  (w_head)
    );

    assign w_n        = (r_active < VCAP) ? r_active : VCAP;
    assign w_in_use   = NW'(r_idx) < NW'(w_n);
    assign w_can_step = !r_out_valid || i_out_ready;
    assign w_in_xfer  = i_in_valid && o_in_ready;
    assign w_ignore   = (r_master != '0 && i_channel == pva_pkg::CHAN_W'(r_master))
                        || i_channel == '0
                        || i_channel > pva_pkg::CHAN_W'(pva_pkg::NUM_CHANNELS)
                        || w_n == '0;

    // head slot processing and ring control
    always_comb begin
        w_ret    = w_head;
        w_gen    = 1'b0;
        w_gen_st = pva_pkg::ST_NONE;
        w_shift  = 1'b0;
        n_fidle  = r_fidle;
        n_pidle  = r_pidle;
        n_bidle  = r_bidle;
        n_pany   = r_pany;
        n_bany   = r_bany;
        n_done   = r_done;
        if (r_state == pva_pkg::S_SCAN && w_can_step) begin
            w_shift = 1'b1;
            unique case (r_op)
                pva_pkg::OP_NOTE_ON: begin
                    if (w_in_use) begin
                        if (!w_head.held && (!r_fidle || w_head.stamp < r_bidle)) begin
                            n_fidle = 1'b1;
                            n_pidle = r_idx;
                            n_bidle = w_head.stamp;
                        end
                        if (r_idx == '0 || w_head.stamp < r_bany) begin
                            n_pany = r_idx;
                            n_bany = w_head.stamp;
                        end
                    end
                end
                pva_pkg::OP_NOTE_OFF: begin
                    if (w_in_use && !r_done && w_head.held && w_head.chan == r_ch
                        && w_head.note == r_note) begin
                        w_ret.held = 1'b0;
                        w_gen      = 1'b1;
                        w_gen_st   = pva_pkg::ST_RELEASED;
                        n_done     = 1'b1;
                    end
                end
                pva_pkg::OP_ALL_OFF: begin
                    if (w_in_use && (r_ch == '0 || w_head.chan == r_ch)) begin
                        w_ret.held = 1'b0;
                        if (w_head.held && r_count < pva_pkg::MAX_RESULTS) begin
                            w_gen    = 1'b1;
                            w_gen_st = pva_pkg::ST_RELEASED;
                        end
                    end
                end
                pva_pkg::OP_LIST: begin
                    if (w_in_use && w_head.held && w_head.chan == r_ch
                        && r_count < pva_pkg::MAX_RESULTS) begin
                        w_gen    = 1'b1;
                        w_gen_st = pva_pkg::ST_MATCHED;
                    end
                end
                default: ;
            endcase
        end else if (r_state == pva_pkg::S_WRITE && w_can_step) begin
            w_shift = 1'b1;
            if (r_idx == r_pick) begin
                w_ret.held  = 1'b1;
                w_ret.chan  = r_ch;
                w_ret.note  = r_note;
                w_ret.stamp = r_stamp;
                w_gen       = 1'b1;
                w_gen_st    = r_pst;
            end
        end
    end

    // sequencing, result staging and output register
    always_comb begin
        n_state      = r_state;
        n_idx        = r_idx;
        n_count      = r_count;
        n_pick       = r_pick;
        n_pst        = r_pst;
        n_stamp      = r_stamp;
        n_pend_valid = r_pend_valid;
        n_pend_voice = r_pend_voice;
        n_pend_st    = r_pend_st;
        n_out_valid  = r_out_valid && !i_out_ready;
        n_out_voice  = r_out_voice;
        n_out_st     = r_out_st;
        n_out_last   = r_out_last;
        if (w_shift) begin
            n_idx = (r_idx == LAST_IDX) ? '0 : r_idx + 1'b1;
        end
        if (w_gen) begin
            n_count      = r_count + 1'b1;
            n_pend_valid = 1'b1;
            n_pend_voice = pva_pkg::VOICE_W'(r_idx);
            n_pend_st    = w_gen_st;
            if (r_pend_valid) begin
                n_out_valid = 1'b1;
                n_out_voice = r_pend_voice;
                n_out_st    = r_pend_st;
                n_out_last  = 1'b0;
            end
        end
        unique case (r_state)
            pva_pkg::S_IDLE: begin
                if (w_in_xfer) begin
                    n_idx        = '0;
                    n_count      = '0;
                    n_pend_valid = 1'b0;
                    if (i_op == pva_pkg::OP_NOTE_ON && w_ignore) begin
                        n_state = pva_pkg::S_DONE;
                    end else begin
                        n_state = pva_pkg::S_SCAN;
                    end
                end
            end
            pva_pkg::S_SCAN: begin
                if (w_shift && r_idx == LAST_IDX) begin
                    if (r_op == pva_pkg::OP_NOTE_ON) begin
                        n_state = pva_pkg::S_WRITE;
                        n_stamp = r_stamp + 1'b1;
                        n_pick  = n_fidle ? n_pidle : n_pany;
                        n_pst   = n_fidle ? pva_pkg::ST_IDLE : pva_pkg::ST_STOLEN;
                    end else begin
                        n_state = pva_pkg::S_DONE;
                    end
                end
            end
            pva_pkg::S_WRITE: begin
                if (w_shift && r_idx == LAST_IDX) begin
                    n_state = pva_pkg::S_DONE;
                end
            end
            pva_pkg::S_DONE: begin
                if (w_can_step) begin
                    n_out_valid = 1'b1;
                    n_out_last  = 1'b1;
                    n_out_voice = r_pend_valid ? r_pend_voice : '0;
                    n_out_st    = r_pend_valid ? r_pend_st : pva_pkg::ST_NONE;
                    n_pend_valid = 1'b0;
                    n_state     = pva_pkg::S_IDLE;
                end
            end
            default: n_state = pva_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= pva_pkg::S_IDLE;
            r_master     <= '0;
            r_active     <= 4'd8;
            r_idx        <= '0;
            r_count      <= '0;
            r_done       <= 1'b0;
            r_fidle      <= 1'b0;
            r_stamp      <= '0;
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_idx        <= n_idx;
            r_count      <= n_count;
            r_stamp      <= n_stamp;
            r_pend_valid <= n_pend_valid;
            r_out_valid  <= n_out_valid;
            if (w_in_xfer) begin
                r_done  <= 1'b0;
                r_fidle <= 1'b0;
            end else begin
                r_done  <= n_done;
                r_fidle <= n_fidle;
            end
            if (i_cfg_valid && o_cfg_ready) begin
                unique case (i_cfg_index)
                    pva_pkg::REG_MASTER: begin
                        r_master <= (i_cfg_data > pva_pkg::MASTER_W'(pva_pkg::NUM_CHANNELS))
                                    ? '0 : i_cfg_data;
                    end
                    pva_pkg::REG_ACTIVE: r_active <= i_cfg_data[pva_pkg::ACTIVE_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (w_in_xfer) begin
            r_op   <= i_op;
            r_ch   <= i_channel;
            r_note <= i_note;
        end
        r_pidle      <= n_pidle;
        r_bidle      <= n_bidle;
        r_pany       <= n_pany;
        r_bany       <= n_bany;
        r_pick       <= n_pick;
        r_pst        <= n_pst;
        r_pend_voice <= n_pend_voice;
        r_pend_st    <= n_pend_st;
        r_out_voice  <= n_out_voice;
        r_out_st     <= n_out_st;
        r_out_last   <= n_out_last;
    end

    assign o_in_ready  = (r_state == pva_pkg::S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_voice     = r_out_voice;
    assign o_status    = r_out_st;
    assign o_last      = r_out_last;

    a_count_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= pva_pkg::MAX_RESULTS)
        else $error("result count beyond cap");

    a_one_release: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == pva_pkg::S_SCAN && r_op == pva_pkg::OP_NOTE_OFF && r_done) |-> !w_gen)
        else $error("note-off released more than one voice");

    a_write_is_note_on: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == pva_pkg::S_WRITE) |-> (r_op == pva_pkg::OP_NOTE_ON && NW'(r_pick) < NW'(w_n)))
        else $error("write pass without a valid note-on pick");

    a_done_flush: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == pva_pkg::S_DONE && w_can_step) |=> (o_out_valid && o_last))
        else $error("event ended without a final result");

    a_ring_home: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == pva_pkg::S_IDLE) |-> (r_idx == '0))
        else $error("ring not back in place while idle");

endmodule

`default_nettype wire

// ===== test/testbench.sv =====
// self-checking testbench for the polyphonic voice allocator
`timescale 1ns / 100ps

module testbench;

    localparam int NUM_VOICES      = 8;
    localparam int CLK_HALF        = 2;
    localparam int RESET_CYCLES    = 7;
    localparam int LIMIT_CYCLES    = 200000;
    localparam int SETTLE_CYCLES   = 4;
    localparam int END_CYCLES      = 2 * NUM_VOICES + 4;
    localparam int RANDOM_PHASES   = 7;
    localparam int ITEMS_PER_PHASE = 26;
    localparam int MAX_REPORTS     = 10;

    typedef struct packed {
        logic [pva_pkg::VOICE_W-1:0]  voice;
        logic [pva_pkg::STATUS_W-1:0] status;
        logic                         last;
    } t_voice_result;

    // tracks the voice table and the queue of results it should produce
    class voice_scoreboard;
        bit                         held [NUM_VOICES];
        logic [pva_pkg::CHAN_W-1:0] chan [NUM_VOICES];
        logic [pva_pkg::NOTE_W-1:0] note [NUM_VOICES];
        logic [31:0]                stamp [NUM_VOICES];
        logic [31:0]                stamp_ctr;
        logic [4:0]                 master;
        logic [3:0]                 active;
        t_voice_result              expected_results [$];
        int                         errors;

        function new();
            for (int i = 0; i < NUM_VOICES; i++) begin
                held[i]  = 1'b0;
                chan[i]  = '0;
                note[i]  = '0;
                stamp[i] = '0;
            end
            stamp_ctr = '0;
            master    = 5'd0;
            active    = 4'd8;
            errors    = 0;
        endfunction

        function int pending();
            return expected_results.size();
        endfunction

        function void write_reg(logic idx, logic [4:0] data);
            if (idx == pva_pkg::REG_MASTER)
                master = (data > pva_pkg::NUM_CHANNELS) ? 5'd0 : data;
            else
                active = data[3:0];
        endfunction

        function void note_event(logic [1:0] op, logic [7:0] ch, logic [6:0] nt);
            int            n;
            int            cnt;
            int            pick;
            bit            found;
            logic [31:0]   best;
            logic [2:0]    st;
            logic [2:0]    res_voice [NUM_VOICES];
            logic [2:0]    res_status [NUM_VOICES];
            t_voice_result r;
            n     = (active < NUM_VOICES) ? int'(active) : NUM_VOICES;
            cnt   = 0;
            found = 1'b0;
            case (op)
                pva_pkg::OP_NOTE_ON: begin
                    if (!((master != 0 && ch == master) || ch < 1 ||
                          ch > pva_pkg::NUM_CHANNELS || n == 0)) begin
                        pick = 0;
                        best = '0;
                        for (int i = 0; i < n; i++) begin
                            if (!held[i] && (!found || stamp[i] < best)) begin
                                found = 1'b1;
                                pick  = i;
                                best  = stamp[i];
                            end
                        end
                        st = pva_pkg::ST_IDLE;
                        if (!found) begin
                            // every voice held: steal the oldest
                            st   = pva_pkg::ST_STOLEN;
                            pick = 0;
                            best = stamp[0];
                            for (int i = 1; i < n; i++) begin
                                if (stamp[i] < best) begin
                                    pick = i;
                                    best = stamp[i];
                                end
                            end
                        end
                        stamp_ctr   = stamp_ctr + 32'd1;
                        chan[pick]  = ch;
                        note[pick]  = nt;
                        held[pick]  = 1'b1;
                        stamp[pick] = stamp_ctr;
                        res_voice[0]  = 3'(pick);
                        res_status[0] = st;
                        cnt = 1;
                    end
                end
                pva_pkg::OP_NOTE_OFF: begin
                    for (int i = 0; i < n; i++) begin
                        if (!found && held[i] && chan[i] == ch && note[i] == nt) begin
                            found         = 1'b1;
                            held[i]       = 1'b0;
                            res_voice[0]  = 3'(i);
                            res_status[0] = pva_pkg::ST_RELEASED;
                            cnt = 1;
                        end
                    end
                end
                pva_pkg::OP_ALL_OFF: begin
                    for (int i = 0; i < n; i++) begin
                        if (ch == 0 || chan[i] == ch) begin
                            if (held[i] && cnt < pva_pkg::MAX_RESULTS) begin
                                res_voice[cnt]  = 3'(i);
                                res_status[cnt] = pva_pkg::ST_RELEASED;
                                cnt++;
                            end
                            held[i] = 1'b0;
                        end
                    end
                end
                default: begin
                    for (int i = 0; i < n; i++) begin
                        if (cnt < pva_pkg::MAX_RESULTS && held[i] && chan[i] == ch) begin
                            res_voice[cnt]  = 3'(i);
                            res_status[cnt] = pva_pkg::ST_MATCHED;
                            cnt++;
                        end
                    end
                end
            endcase
            if (cnt == 0) begin
                res_voice[0]  = 3'd0;
                res_status[0] = pva_pkg::ST_NONE;
                cnt = 1;
            end
            for (int k = 0; k < cnt; k++) begin
                r.voice  = res_voice[k];
                r.status = res_status[k];
                r.last   = (k == cnt - 1);
                expected_results.push_back(r);
            end
        endfunction

        function void check_result(logic [2:0] v, logic [2:0] s, logic l);
            t_voice_result want;
            if (expected_results.size() == 0) begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("unexpected result: voice %0d status %0d last %0d", v, s, l);
            end else begin
                want = expected_results.pop_front();
                if (want.voice !== v || want.status !== s || want.last !== l) begin
                    errors++;
                    if (errors <= MAX_REPORTS)
                        $display("mismatch: expected voice %0d status %0d last %0d, %s %0d %0d %0d",
                                 want.voice, want.status, want.last,
                                 "got voice/status/last", v, s, l);
                end
            end
        endfunction
    endclass

    logic                          i_clk       = 1'b0;
    logic                          i_rst_n     = 1'b0;
    logic                          i_in_valid  = 1'b0;
    logic [1:0]                    i_op        = '0;
    logic [pva_pkg::CHAN_W-1:0]    i_channel   = '0;
    logic [pva_pkg::NOTE_W-1:0]    i_note      = '0;
    logic                          i_out_ready = 1'b0;
    logic                          i_cfg_valid = 1'b0;
    logic                          i_cfg_index = 1'b0;
    logic [pva_pkg::MASTER_W-1:0]  i_cfg_data  = '0;
    logic                          o_in_ready;
    logic                          o_out_valid;
    logic [pva_pkg::VOICE_W-1:0]   o_voice;
    logic [pva_pkg::STATUS_W-1:0]  o_status;
    logic                          o_last;
    logic                          o_cfg_ready;

    voice_scoreboard sb;
    int cycle_count = 0;
    int burst_left  = 0;
    int max_gap     = 0;
    int rx_count    = 0;
    int rx_mode     = 0;

    poly_voice_allocator #(
        .VOICES (NUM_VOICES)
    ) u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_op        (i_op),
        .i_channel   (i_channel),
        .i_note      (i_note),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_voice     (o_voice),
        .o_status    (o_status),
        .o_last      (o_last),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #CLK_HALF i_clk = 1'b1;
        #CLK_HALF i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == LIMIT_CYCLES) begin
            $display("testbench failed");
            $finish;
        end
    end

    // result checked before a new event is noted: both can transfer on one edge
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready)
                sb.write_reg(i_cfg_index, i_cfg_data);
            if (o_out_valid && i_out_ready)
                sb.check_result(o_voice, o_status, o_last);
            if (i_in_valid && o_in_ready)
                sb.note_event(i_op, i_channel, i_note);
        end
    end

    // receiver stall pattern, switching style every so often
    always @(negedge i_clk) begin
        rx_count++;
        if (rx_count % 97 == 0)
            rx_mode = $urandom_range(0, 3);
        case (rx_mode)
            0:       i_out_ready <= 1'b1;
            1:       i_out_ready <= ($urandom_range(0, 3) != 0);
            2:       i_out_ready <= ((rx_count % 5) < 3);
            default: i_out_ready <= ($urandom_range(0, 7) == 0);
        endcase
    end

    task automatic send_event(input logic [1:0] op, input logic [7:0] ch,
                              input logic [6:0] nt);
        int gap;
        i_op       <= op;
        i_channel  <= ch;
        i_note     <= nt;
        i_in_valid <= 1'b1;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        @(negedge i_clk);
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = $urandom_range(0, 7);
            gap = (max_gap == 0) ? 0 : $urandom_range(0, max_gap);
            if (gap > 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
        end
    endtask

    task automatic cfg_write(input logic idx, input logic [4:0] data);
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        i_cfg_valid <= 1'b1;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic set_config(input logic [4:0] master_data, input logic [4:0] active_data);
        cfg_write(pva_pkg::REG_MASTER, master_data);
        cfg_write(pva_pkg::REG_ACTIVE, active_data);
        i_cfg_valid <= 1'b0;
    endtask

    // stop sending and let every pending result come out
    task automatic drain();
        i_in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic random_event();
        int         r;
        int         k;
        logic [1:0] op;
        logic [7:0] ch;
        logic [6:0] nt;
        r  = $urandom_range(0, 99);
        k  = $urandom_range(0, NUM_VOICES - 1);
        ch = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(1, 16)) : 8'($urandom_range(1, 4));
        nt = 7'($urandom_range(58, 65));
        if (r < 45) begin
            op = pva_pkg::OP_NOTE_ON;
        end else if (r < 70) begin
            op = pva_pkg::OP_NOTE_OFF;
            if (sb.held[k]) begin
                ch = sb.chan[k];
                nt = sb.note[k];
            end
        end else if (r < 82) begin
            op = pva_pkg::OP_LIST;
            if (sb.held[k])
                ch = sb.chan[k];
        end else if (r < 88) begin
            op = pva_pkg::OP_ALL_OFF;
            if ($urandom_range(0, 2) == 0)
                ch = 8'd0;
        end else begin
            op = 2'($urandom_range(0, 3));
            ch = 8'($urandom_range(0, 255));
            nt = 7'($urandom_range(0, 127));
        end
        send_event(op, ch, nt);
    endtask

    initial begin
        logic [4:0] m;
        int         a;
        sb = new();
        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        max_gap = 6;

        // default settings: ignored channels, fill, steal, release, list, all-notes-off
        send_event(pva_pkg::OP_NOTE_ON, 8'd0, 7'd0);
        send_event(pva_pkg::OP_NOTE_ON, 8'd17, 7'd127);
        send_event(pva_pkg::OP_NOTE_ON, 8'd1, 7'd0);
        send_event(pva_pkg::OP_NOTE_ON, 8'd16, 7'd127);
        send_event(pva_pkg::OP_NOTE_ON, 8'd2, 7'd60);
        send_event(pva_pkg::OP_NOTE_ON, 8'd2, 7'd64);
        send_event(pva_pkg::OP_NOTE_ON, 8'd3, 7'd67);
        send_event(pva_pkg::OP_NOTE_ON, 8'd1, 7'd60);
        send_event(pva_pkg::OP_NOTE_ON, 8'd4, 7'd72);
        send_event(pva_pkg::OP_NOTE_ON, 8'd5, 7'd48);
        send_event(pva_pkg::OP_NOTE_ON, 8'd6, 7'd50);
        send_event(pva_pkg::OP_NOTE_OFF, 8'd2, 7'd60);
        send_event(pva_pkg::OP_NOTE_OFF, 8'd2, 7'd60);
        send_event(pva_pkg::OP_NOTE_ON, 8'd8, 7'd30);
        send_event(pva_pkg::OP_LIST, 8'd2, 7'd0);
        send_event(pva_pkg::OP_LIST, 8'd9, 7'd0);
        send_event(pva_pkg::OP_ALL_OFF, 8'd4, 7'd0);
        send_event(pva_pkg::OP_ALL_OFF, 8'd0, 7'd0);
        send_event(pva_pkg::OP_ALL_OFF, 8'd0, 7'd0);
        drain();

        // master channel at the top of the range
        set_config(5'd16, 5'd8);
        send_event(pva_pkg::OP_NOTE_ON, 8'd16, 7'd100);
        send_event(pva_pkg::OP_NOTE_ON, 8'd15, 7'd101);
        drain();

        // out-of-range master stores zero, no voices in use
        set_config(5'd31, 5'd0);
        send_event(pva_pkg::OP_NOTE_ON, 8'd1, 7'd10);
        send_event(pva_pkg::OP_NOTE_OFF, 8'd15, 7'd101);
        send_event(pva_pkg::OP_LIST, 8'd15, 7'd0);
        drain();

        // voice count above the table size, then a single voice
        set_config(5'd21, 5'd31);
        send_event(pva_pkg::OP_NOTE_ON, 8'd1, 7'd11);
        drain();
        set_config(5'd0, 5'd1);
        send_event(pva_pkg::OP_NOTE_ON, 8'd3, 7'd12);
        send_event(pva_pkg::OP_NOTE_ON, 8'd3, 7'd13);
        drain();

        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            case ($urandom_range(0, 3))
                0:       m = 5'd0;
                1:       m = 5'($urandom_range(1, 4));
                2:       m = 5'd16;
                default: m = 5'($urandom_range(17, 31));
            endcase
            if (phase == 1)
                a = 1;
            else if ($urandom_range(0, 9) == 0)
                a = 0;
            else
                a = $urandom_range(2, 15);
            set_config(m, {1'($urandom_range(0, 1)), 4'(a)});
            max_gap = (phase % 3 == 0) ? 0 : 12;
            repeat (ITEMS_PER_PHASE) random_event();
            drain();
        end

        repeat (END_CYCLES) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("testbench passed");
        else
            $display("testbench failed");
        $finish;
    end

endmodule

// ===== filelist.f =====
design/pva_pkg.sv
design/pva_cell.sv
design/pva_ring.sv
design/poly_voice_allocator.sv
test/testbench.sv
